### sv/cfv_pkg.sv
// shared constants, types and register codes for the cube frustum visibility test
package cfv_pkg;

  localparam int CFV_COORD_BITS     = 16;
  localparam int CFV_COEF_FRAC_BITS = 8;

  localparam int COEF_W    = 16;
  localparam int N_ROWS    = 4;
  localparam int N_COLS    = 4;
  localparam int N_AXES    = 3;
  localparam int N_CORNERS = 8;
  // sum of three +/- coefficients
  localparam int OFS_W     = COEF_W + 2;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 64;

  // matrix rows, in register order
  localparam int ROW_X = 0;
  localparam int ROW_Y = 1;
  localparam int ROW_Z = 2;
  localparam int ROW_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_MAT_ROW_X = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAT_ROW_Y = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_MAT_ROW_Z = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_MAT_ROW_W = CFG_IDX_W'(3);

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [OFS_W-1:0]  ofs_t;

  // per-stage load enables
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } cfv_pipe_en_t;

endpackage

### sv/cfv_ifs.sv
// valid/ready channel interfaces: cube centers, visibility results, register writes
interface cfv_item_if import cfv_pkg::*; #(
  parameter int COORD_BITS = CFV_COORD_BITS
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] center_x;
  logic signed [COORD_BITS-1:0] center_y;
  logic signed [COORD_BITS-1:0] center_z;

  modport source (output valid, center_x, center_y, center_z, input ready);
  modport sink   (input valid, center_x, center_y, center_z, output ready);
endinterface

interface cfv_res_if;
  logic valid;
  logic ready;
  logic in_frustum;

  modport source (output valid, in_frustum, input ready);
  modport sink   (input valid, in_frustum, output ready);
endinterface

interface cfv_cfg_if import cfv_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### sv/cfv_cfg_regs.sv
// matrix registers and the per-corner coefficient offsets derived from them
module cfv_cfg_regs import cfv_pkg::*; #(
  parameter int COEF_FRAC_BITS = CFV_COEF_FRAC_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cfv_cfg_if.sink    cfg_i,
  output coef_t      coef_o [N_ROWS][N_COLS],
  output ofs_t       ofs_o  [N_ROWS][N_CORNERS]
);

  logic [CFG_DATA_W-1:0] rows_q [N_ROWS];
  ofs_t                  ofs_d  [N_ROWS][N_CORNERS];
  ofs_t                  ofs_q  [N_ROWS][N_CORNERS];

  assign cfg_i.ready = 1'b1;

  // reset value is the identity matrix
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < N_ROWS; r++) begin
        rows_q[r] <= CFG_DATA_W'(1) << (COEF_W * r + COEF_FRAC_BITS);
      end
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        REG_MAT_ROW_X: rows_q[ROW_X] <= cfg_i.data;
        REG_MAT_ROW_Y: rows_q[ROW_Y] <= cfg_i.data;
        REG_MAT_ROW_Z: rows_q[ROW_Z] <= cfg_i.data;
        REG_MAT_ROW_W: rows_q[ROW_W] <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int r = 0; r < N_ROWS; r++) begin
      for (int c = 0; c < N_COLS; c++) begin
        coef_o[r][c] = rows_q[r][COEF_W*c +: COEF_W];
      end
    end
  end

  // corner k takes +a on axis j when bit j of k is set, -a otherwise
  always_comb begin
    for (int r = 0; r < N_ROWS; r++) begin
      for (int k = 0; k < N_CORNERS; k++) begin
        ofs_d[r][k] = '0;
        for (int a = 0; a < N_AXES; a++) begin
          if (((k >> a) & 1) != 0) begin
            ofs_d[r][k] = ofs_d[r][k] + OFS_W'(coef_o[r][a]);
          end else begin
            ofs_d[r][k] = ofs_d[r][k] - OFS_W'(coef_o[r][a]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ofs_q <= ofs_d;
  end

  assign ofs_o = ofs_q;

endmodule

### sv/cfv_xform.sv
// stages 1-3: center products, doubled row sums, clip values of all eight corners
module cfv_xform import cfv_pkg::*; #(
  parameter int COORD_BITS = CFV_COORD_BITS,
  localparam int VW = COORD_BITS + COEF_W + 3
) (
  input  logic                         clk_i,
  input  cfv_pipe_en_t                 en_i,
  input  logic signed [COORD_BITS-1:0] center_x_i,
  input  logic signed [COORD_BITS-1:0] center_y_i,
  input  logic signed [COORD_BITS-1:0] center_z_i,
  input  coef_t                        coef_i   [N_ROWS][N_COLS],
  input  ofs_t                         ofs_i    [N_ROWS][N_CORNERS],
  output logic signed [VW-1:0]         corner_o [N_ROWS][N_CORNERS]
);

  localparam int PW = COORD_BITS + COEF_W;

  logic signed [COORD_BITS-1:0] ctr [N_AXES];
  logic signed [PW-1:0]         prod_q   [N_ROWS][N_AXES];
  logic signed [VW-1:0]         sum_d    [N_ROWS];
  logic signed [VW-1:0]         base_q   [N_ROWS];
  logic signed [VW-1:0]         corner_q [N_ROWS][N_CORNERS];

  assign ctr[0] = center_x_i;
  assign ctr[1] = center_y_i;
  assign ctr[2] = center_z_i;

  // stage 1: one multiplier per row and axis
  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      for (int r = 0; r < N_ROWS; r++) begin
        for (int a = 0; a < N_AXES; a++) begin
          prod_q[r][a] <= PW'(coef_i[r][a]) * PW'(ctr[a]);
        end
      end
    end
  end

  // stage 2: base = 2 * (row . (c, 1))
  always_comb begin
    for (int r = 0; r < N_ROWS; r++) begin
      sum_d[r] = (VW'(prod_q[r][0]) + VW'(prod_q[r][1]))
               + (VW'(prod_q[r][2]) + VW'(coef_i[r][N_AXES]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      for (int r = 0; r < N_ROWS; r++) begin
        base_q[r] <= sum_d[r] <<< 1;
      end
    end
  end

  // stage 3: corner value = base +/- a0 +/- a1 +/- a2
  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      for (int r = 0; r < N_ROWS; r++) begin
        for (int k = 0; k < N_CORNERS; k++) begin
          corner_q[r][k] <= base_q[r] + VW'(ofs_i[r][k]);
        end
      end
    end
  end

  assign corner_o = corner_q;

endmodule

### sv/cfv_test.sv
// stages 4-5: per-corner clip volume test and the any-corner result register
module cfv_test import cfv_pkg::*; #(
  parameter int COORD_BITS = CFV_COORD_BITS,
  localparam int VW = COORD_BITS + COEF_W + 3
) (
  input  logic                 clk_i,
  input  cfv_pipe_en_t         en_i,
  input  logic signed [VW-1:0] corner_i [N_ROWS][N_CORNERS],
  output logic                 in_frustum_o
);

  logic [N_CORNERS-1:0] hit_d;
  logic [N_CORNERS-1:0] hit_q;
  logic                 in_frustum_q;

  function automatic logic [VW-1:0] mag(input logic signed [VW-1:0] v);
    return v[VW-1] ? VW'(-v) : VW'(v);
  endfunction

  // zero w skips the corner
  always_comb begin
    for (int k = 0; k < N_CORNERS; k++) begin
      hit_d[k] = (corner_i[ROW_W][k] != '0)
              && (mag(corner_i[ROW_X][k]) <= mag(corner_i[ROW_W][k]))
              && (mag(corner_i[ROW_Y][k]) <= mag(corner_i[ROW_W][k]))
              && (mag(corner_i[ROW_Z][k]) <= mag(corner_i[ROW_W][k]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      hit_q <= hit_d;
    end
    if (en_i.s5) begin
      in_frustum_q <= |hit_q;
    end
  end

  assign in_frustum_o = in_frustum_q;

endmodule

### sv/cube_frustum_visibility_test.sv
// top level of the unit-cube clip-space visibility test
//
// in_i carries one cube center (center_x/y/z, signed) per transaction; out_o
// returns one in_frustum bit per center, in input order. in_frustum is 1 when
// any of the cube's eight corners, transformed by the 4x4 matrix, has w != 0
// and |x|, |y|, |z| <= |w|.
// cfg_i writes one 64-bit matrix row per transaction (index 0..3 = rows x, y,
// z, w; other indexes are dropped); it is always ready. Write only while no
// center is in flight.
// a center accepted on in_i passes through five register stages (products,
// row sums, corner values, corner tests, result register) before its result
// appears on out_o. Throughput is one center per cycle unless out_o stalls
// and the stages fill up.
// when out_o is stalled, stages fill up behind the result register; each
// stage holds while the one after it is full and held, and in_i.ready drops
// only once all five stages are full. Nothing is lost or repeated.
// reset clears all stage valid bits and loads the identity matrix (one at
// the configured fraction position on the diagonal).
module cube_frustum_visibility_test import cfv_pkg::*; #(
  parameter int COORD_BITS     = CFV_COORD_BITS,
  parameter int COEF_FRAC_BITS = CFV_COEF_FRAC_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cfv_item_if.sink   in_i,
  cfv_res_if.source  out_o,
  cfv_cfg_if.sink    cfg_i
);

  localparam int VW = COORD_BITS + COEF_W + 3;

  coef_t                coef   [N_ROWS][N_COLS];
  ofs_t                 ofs    [N_ROWS][N_CORNERS];
  logic signed [VW-1:0] corner [N_ROWS][N_CORNERS];
  cfv_pipe_en_t         en;

  // stage valid bits, v5 is the output register
  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  // a stage loads when it is empty or the next one loads
  always_comb begin
    en.s5 = !v5_q || out_o.ready;
    en.s4 = !v4_q || en.s5;
    en.s3 = !v3_q || en.s4;
    en.s2 = !v2_q || en.s3;
    en.s1 = !v1_q || en.s2;
  end

  assign in_i.ready = en.s1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en.s1) begin
        v1_q <= in_i.valid;
      end
      if (en.s2) begin
        v2_q <= v1_q;
      end
      if (en.s3) begin
        v3_q <= v2_q;
      end
      if (en.s4) begin
        v4_q <= v3_q;
      end
      if (en.s5) begin
        v5_q <= v4_q;
      end
    end
  end

  assign out_o.valid = v5_q;

  // matrix registers and precomputed corner offsets
  cfv_cfg_regs #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .coef_o (coef),
    .ofs_o  (ofs)
  );

  // stages 1-3
  cfv_xform #(
    .COORD_BITS (COORD_BITS)
  ) u_xform (
    .clk_i      (clk_i),
    .en_i       (en),
    .center_x_i (in_i.center_x),
    .center_y_i (in_i.center_y),
    .center_z_i (in_i.center_z),
    .coef_i     (coef),
    .ofs_i      (ofs),
    .corner_o   (corner)
  );

  // stages 4-5
  cfv_test #(
    .COORD_BITS (COORD_BITS)
  ) u_test (
    .clk_i        (clk_i),
    .en_i         (en),
    .corner_i     (corner),
    .in_frustum_o (out_o.in_frustum)
  );

endmodule

### sv/cfv_checker.sv
// port-level checks for the visibility test, bound to the top level
module cfv_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic in_frustum_i
);

  localparam int          MAX_INFLIGHT = 5;
  localparam int unsigned CNT_W        = 4;

  logic [CNT_W-1:0] cnt_d, cnt_q;
  logic             in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (in_acc && !out_acc) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (!in_acc && out_acc) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // never more centers in flight than pipeline stages
  a_inflight_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_INFLIGHT))
    else $error("more transactions in flight than stages");

  // no result without an outstanding center
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cnt_q != '0)
    else $error("result without a pending input transaction");

  // an empty output register never blocks the input
  a_ready_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled while output register is empty");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(in_frustum_i))
    else $error("stalled result changed or dropped");

endmodule

bind cube_frustum_visibility_test cfv_checker u_cfv_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .in_frustum_i (out_o.in_frustum)
);
